FILE: sv/mlps_pkg.sv
package mlps_pkg;

  localparam int ADDR_W      = 5;
  localparam int STORE_DEPTH = 32;
  localparam int WEIGHT_W    = 16;
  localparam int ACT_W       = 13;
  localparam int ACT_FRAC    = 12;
  localparam int ACT_ONE     = 4096;
  localparam int MUL_W       = 14;
  localparam int PROD_W      = WEIGHT_W + MUL_W;
  localparam int IN_BITS_W   = 3;
  localparam int TABLE_LAST  = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // round(4096 * s(k/16)) for k = 0..32, s(x) = 1/(1+exp(-5x)).
  localparam logic [ACT_W-1:0] SIG_TABLE [0:TABLE_LAST] = '{
    13'd2048, 13'd2365, 13'd2668, 13'd2943, 13'd3184, 13'd3386, 13'd3551,
    13'd3683, 13'd3785, 13'd3864, 13'd3924, 13'd3968, 13'd4002, 13'd4027,
    13'd4045, 13'd4059, 13'd4069, 13'd4076, 13'd4081, 13'd4085, 13'd4088,
    13'd4090, 13'd4092, 13'd4093, 13'd4094, 13'd4094, 13'd4095, 13'd4095,
    13'd4095, 13'd4096, 13'd4096, 13'd4096, 13'd4096
  };

  typedef struct packed {
    logic                       cmd;
    logic [ADDR_W-1:0]          weight_addr;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic [IN_BITS_W-1:0]       input_bits;
  } in_word_t;

  typedef struct packed {
    logic [ACT_W-1:0] out_first;
    logic [ACT_W-1:0] out_second;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

FILE: sv/mlps_store.sv
module mlps_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [mlps_pkg::ADDR_W-1:0]          wr_addr,
  input  logic signed [mlps_pkg::WEIGHT_W-1:0] wr_data,
  input  logic [mlps_pkg::ADDR_W-1:0]          rd_addr,
  output logic signed [mlps_pkg::WEIGHT_W-1:0] rd_data
);
  import mlps_pkg::*;

  logic signed [WEIGHT_W-1:0] mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]     written;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

FILE: sv/mlps_mac.sv
module mlps_mac #(
  parameter int ACC_W = 33
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mlps_pkg::mac_ctl_t                   ctl,
  input  logic signed [mlps_pkg::MUL_W-1:0]    mul,
  input  logic signed [mlps_pkg::WEIGHT_W-1:0] weight,
  output logic signed [ACC_W-1:0]              acc,
  output logic                                 done
);
  import mlps_pkg::*;

  mac_ctl_t                 r_ctl;
  logic signed [MUL_W-1:0]  r_mul;
  mac_ctl_t                 p_ctl;
  logic signed [PROD_W-1:0] prod;

  // The weight arrives in the cycle after its address, so the control and
  // multiplier are delayed to line up with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_ctl <= '0;
      p_ctl <= '0;
      done  <= 1'b0;
    end else begin
      r_ctl <= ctl;
      p_ctl <= r_ctl;
      done  <= p_ctl.vld && p_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    r_mul <= mul;
    prod  <= weight * r_mul;
    if (p_ctl.vld) begin
      acc <= p_ctl.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

endmodule

FILE: sv/mlps_sigmoid.sv
module mlps_sigmoid #(
  parameter int ACC_W     = 33,
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              net_vld,
  input  logic                              rnd,
  input  logic signed [ACC_W-1:0]           acc,
  output logic                              y_vld,
  output logic [mlps_pkg::ACT_W-1:0]        y
);
  import mlps_pkg::*;

  localparam int A_W     = FRAC_BITS + 4;
  localparam int STEP_SH = FRAC_BITS - 4;
  localparam int HALF    = 1 << (STEP_SH - 1);
  localparam int IW      = ACT_W + STEP_SH + 1;
  localparam int SAT_LIM = 8 << FRAC_BITS;
  localparam int ROUND_HALF = 1 << (ACT_FRAC - 1);
  localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(SAT_LIM);
  localparam logic signed [ACC_W-1:0] NEG_LIM = -POS_LIM;

  logic signed [ACC_W-1:0] rounded;
  logic signed [ACC_W-1:0] net;
  logic signed [ACC_W-1:0] sat;
  logic signed [ACC_W-1:0] mag;
  logic                    a_vld;
  logic                    a_neg;
  logic [A_W-1:0]          a_mag;

  logic [4:0]              idx;
  logic [5:0]              nxt_idx;
  logic [STEP_SH-1:0]      frac;
  logic [ACT_W-1:0]        base;
  logic [ACT_W-1:0]        diff;
  logic [IW-1:0]           interp;
  logic [ACT_W-1:0]        pos_y;
  logic [ACT_W-1:0]        y_next;

  // Output-layer sums carry 12 extra fraction bits from the activations and
  // are rounded back to the weight format before saturation.
  always_comb begin
    rounded = (acc + ACC_W'(ROUND_HALF)) >>> ACT_FRAC;
    net     = rnd ? rounded : acc;
    if (net > POS_LIM) begin
      sat = POS_LIM;
    end else if (net < NEG_LIM) begin
      sat = NEG_LIM;
    end else begin
      sat = net;
    end
    mag = sat[ACC_W-1] ? -sat : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      y_vld <= 1'b0;
    end else begin
      a_vld <= net_vld;
      y_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_neg <= sat[ACC_W-1];
    a_mag <= mag[A_W-1:0];
    y     <= y_next;
  end

  // Linear interpolation between table points spaced 1/16 apart.
  always_comb begin
    idx     = a_mag[STEP_SH +: 5];
    nxt_idx = {1'b0, idx} + 6'd1;
    frac    = a_mag[STEP_SH-1:0];
    base    = SIG_TABLE[idx];
    diff    = SIG_TABLE[nxt_idx] - base;
    interp  = (IW'(diff) * IW'(frac) + IW'(HALF)) >> STEP_SH;
    if ((a_mag >> STEP_SH) > A_W'(TABLE_LAST - 1)) begin
      pos_y = ACT_W'(ACT_ONE);
    end else begin
      pos_y = base + interp[ACT_W-1:0];
    end
    y_next = a_neg ? ACT_W'(ACT_ONE) - pos_y : pos_y;
  end

endmodule

FILE: sv/mlp_sigmoid_inference.sv
// Forward pass of a small two-layer perceptron with logistic units.
//
// Input channel (item_valid / item_ready / item): a word with cmd = write
// loads weight_value into the 32-word weight store at weight_addr and gives
// no result. A word with cmd = evaluate runs the network on input_bits and
// gives one result word (result_valid / result_ready / result) holding the
// two output activations in Q1.12.
//
// A write leaves item_ready high. An evaluation runs every weight through one
// shared multiply-accumulate unit, one weight per cycle, and each neuron then
// waits for the accumulator and the two-stage sigmoid to drain; item_ready is
// low while an evaluation runs.
//
// Reset clears the weight store to zero and empties the result register.
// The result word sits in its own register: while the receiver stalls, new
// writes and the next evaluation are still taken, and only the end of that
// evaluation waits for the register to free up.
module mlp_sigmoid_inference #(
  parameter int NUM_INPUTS = 3,
  parameter int NUM_HIDDEN = 5,
  parameter int FRAC_BITS  = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mlps_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output mlps_pkg::out_word_t result
);
  import mlps_pkg::*;

  localparam int MAXT  = (NUM_INPUTS > NUM_HIDDEN) ? NUM_INPUTS : NUM_HIDDEN;
  localparam int TW    = $clog2(MAXT + 1);
  localparam int NW    = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int ACC_W = PROD_W + $clog2(MAXT + 2);
  localparam logic [ADDR_W-1:0] HID_STRIDE = ADDR_W'(NUM_INPUTS + 1);
  localparam logic [ADDR_W-1:0] OUT_STRIDE = ADDR_W'(NUM_HIDDEN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state;
  logic                 layer;
  logic [NW-1:0]        n;
  logic [TW-1:0]        t;
  logic [TW-1:0]        last_t;
  logic [ADDR_W-1:0]    row;
  logic [ADDR_W-1:0]    rd_addr;
  logic [IN_BITS_W-1:0] bits;
  logic [ACT_W-1:0]     hid [NUM_HIDDEN];
  logic [ACT_W-1:0]     res_first;
  logic [ACT_W-1:0]     res_second;

  logic                       accept;
  logic                       wr_en;
  mac_ctl_t                   ctl;
  logic signed [MUL_W-1:0]    mul;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [ACC_W-1:0]    acc;
  logic                       acc_done;
  logic                       y_vld;
  logic [ACT_W-1:0]           y;
  logic                       slot_free;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign wr_en      = accept && (item.cmd == CMD_WRITE);
  assign slot_free  = !result_valid || result_ready;

  assign last_t  = layer ? TW'(NUM_HIDDEN) : TW'(NUM_INPUTS);
  assign rd_addr = ADDR_W'(row + ADDR_W'(t));

  // Hidden terms multiply by the input bit (inputs past the third read as
  // zero) and the threshold by -1; output terms multiply by the hidden
  // activation and the threshold by -1.0 in Q1.12.
  always_comb begin
    ctl.vld   = (state == ST_ISSUE);
    ctl.first = (t == '0);
    ctl.last  = (t == last_t);
    if (!layer) begin
      if (t == TW'(NUM_INPUTS)) begin
        mul = -MUL_W'(1);
      end else if ((32'(t) < 32'd3) && bits[2'(t)]) begin
        mul = MUL_W'(1);
      end else begin
        mul = '0;
      end
    end else begin
      if (t == TW'(NUM_HIDDEN)) begin
        mul = -MUL_W'(ACT_ONE);
      end else begin
        mul = MUL_W'({1'b0, hid[NW'(t)]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      layer        <= 1'b0;
      n            <= '0;
      t            <= '0;
      row          <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (item.cmd == CMD_EVAL)) begin
            state <= ST_ISSUE;
            layer <= 1'b0;
            n     <= '0;
            t     <= '0;
            row   <= '0;
          end
        end
        ST_ISSUE: begin
          if (t == last_t) begin
            t     <= '0;
            state <= ST_WAIT;
          end else begin
            t <= t + TW'(1);
          end
        end
        ST_WAIT: begin
          if (y_vld) begin
            state <= ST_ISSUE;
            if (!layer) begin
              row <= row + HID_STRIDE;
              if (n == NW'(NUM_HIDDEN - 1)) begin
                layer <= 1'b1;
                n     <= '0;
              end else begin
                n <= n + NW'(1);
              end
            end else begin
              row <= row + OUT_STRIDE;
              if (n == '0) begin
                n <= NW'(1);
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bits <= item.input_bits;
    end
    if ((state == ST_WAIT) && y_vld) begin
      if (!layer) begin
        hid[n] <= y;
      end else if (n == '0) begin
        res_first <= y;
      end else begin
        res_second <= y;
      end
    end
    if ((state == ST_DONE) && slot_free) begin
      result.out_first  <= res_first;
      result.out_second <= res_second;
    end
  end

  mlps_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (item.weight_addr),
    .wr_data (item.weight_value),
    .rd_addr (rd_addr),
    .rd_data (weight)
  );

  mlps_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .mul    (mul),
    .weight (weight),
    .acc    (acc),
    .done   (acc_done)
  );

  mlps_sigmoid #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_sigmoid (
    .clk     (clk),
    .rst     (rst),
    .net_vld (acc_done),
    .rnd     (layer),
    .acc     (acc),
    .y_vld   (y_vld),
    .y       (y)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mlps_pkg::*;

  localparam int N_IN        = 3;
  localparam int N_HID       = 5;
  localparam int N_OUT       = 2;
  localparam int HID_ROW     = N_IN + 1;
  localparam int OUT_BASE    = N_HID * HID_ROW;
  localparam int OUT_ROW     = N_HID + 1;
  localparam int UNITY       = 4096;
  localparam int NET_LIMIT   = 8 << 12;
  localparam int SEG_SHIFT   = 8;
  localparam int SEGMENTS    = 32;
  localparam int PHASE_WORDS = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;

  // Logistic curve with gain five, sampled every 1/16 from 0 to 2.
  localparam int LOGISTIC_PTS [0:SEGMENTS] = '{
    2048, 2365, 2668, 2943, 3184, 3386, 3551, 3683, 3785, 3864, 3924,
    3968, 4002, 4027, 4045, 4059, 4069, 4076, 4081, 4085, 4088, 4090,
    4092, 4093, 4094, 4094, 4095, 4095, 4095, 4096, 4096, 4096, 4096
  };

  class perceptron_board;
    logic signed [WEIGHT_W-1:0] weights [STORE_DEPTH];
    out_word_t expected_outputs [$];
    int errors;

    function new();
      foreach (weights[i]) weights[i] = '0;
      errors = 0;
    endfunction

    function int logistic5(longint net);
      longint clipped;
      longint mag;
      int seg;
      int frac;
      int y;
      clipped = net > NET_LIMIT ? NET_LIMIT : (net < -NET_LIMIT ? -NET_LIMIT : net);
      mag = clipped < 0 ? -clipped : clipped;
      seg = int'(mag >> SEG_SHIFT);
      frac = int'(mag & ((1 << SEG_SHIFT) - 1));
      if (seg >= SEGMENTS) begin
        y = UNITY;
      end else begin
        y = LOGISTIC_PTS[seg] + ((LOGISTIC_PTS[seg+1] - LOGISTIC_PTS[seg]) * frac
            + (1 << (SEG_SHIFT - 1))) / (1 << SEG_SHIFT);
      end
      return clipped < 0 ? UNITY - y : y;
    endfunction

    function out_word_t forward_pass(logic [IN_BITS_W-1:0] pattern);
      longint acc;
      int hidden [N_HID];
      int act [N_OUT];
      out_word_t r;
      for (int m = 0; m < N_HID; m++) begin
        acc = 0;
        for (int i = 0; i < N_IN; i++)
          if (pattern[i]) acc += weights[m*HID_ROW + i];
        acc -= weights[m*HID_ROW + N_IN];
        hidden[m] = logistic5(acc);
      end
      for (int k = 0; k < N_OUT; k++) begin
        acc = 0;
        for (int m = 0; m < N_HID; m++)
          acc += longint'(weights[OUT_BASE + k*OUT_ROW + m]) * hidden[m];
        acc -= longint'(weights[OUT_BASE + k*OUT_ROW + N_HID]) * UNITY;
        // Round the Q.24 sum back to Q.12, rounding halves upward.
        act[k] = logistic5((acc + 2048) >>> ACT_FRAC);
      end
      r.out_first  = act[0][ACT_W-1:0];
      r.out_second = act[1][ACT_W-1:0];
      return r;
    endfunction

    function void note_input(in_word_t w);
      if (w.cmd == CMD_WRITE)
        weights[w.weight_addr] = w.weight_value;
      else
        expected_outputs.push_back(forward_pass(w.input_bits));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: first=%0d second=%0d",
                   got.out_first, got.out_second);
        return;
      end
      want = expected_outputs.pop_front();
      if (got.out_first !== want.out_first || got.out_second !== want.out_second) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result mismatch: first exp %0d got %0d, second exp %0d got %0d",
                   want.out_first, got.out_first, want.out_second, got.out_second);
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void flag_leftover();
      if (expected_outputs.size() != 0) begin
        errors += expected_outputs.size();
        $display("%0d expected result words never arrived", expected_outputs.size());
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  perceptron_board board = new();

  mlp_sigmoid_inference uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk)
    result_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

  // Both sides are sampled before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) board.note_input(item);
    if (!rst && result_valid && result_ready) board.check_result(result);
  end

  function automatic in_word_t make_write(int addr, int value, int pattern);
    in_word_t w;
    w.cmd          = CMD_WRITE;
    w.weight_addr  = addr[ADDR_W-1:0];
    w.weight_value = value[WEIGHT_W-1:0];
    w.input_bits   = pattern[IN_BITS_W-1:0];
    return w;
  endfunction

  function automatic in_word_t make_eval(int pattern);
    in_word_t w;
    w.cmd          = CMD_EVAL;
    w.weight_addr  = ADDR_W'($urandom);
    w.weight_value = WEIGHT_W'($urandom);
    w.input_bits   = pattern[IN_BITS_W-1:0];
    return w;
  endfunction

  function automatic int pick_weight();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    return $urandom_range(0, 65535);
      2:       return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      3:       return $urandom_range(0, 2) - 1;
      default: return $urandom_range(0, 12288) - 6144;
    endcase
  endfunction

  // Mostly loads and evaluations with random content, plus an occasional
  // write whose fields are all random.
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42)
      w = make_eval($urandom_range(0, 7));
    else if (pick < 48)
      w = make_write($urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 7));
    else
      w = make_write($urandom_range(0, 31), pick_weight(), $urandom_range(0, 7));
    return w;
  endfunction

  // Valid stays high from one word to the next unless the sender idles.
  task automatic send_word(input in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t directed [$];
    int idle_plan [4][2];

    idle_plan = '{'{0, 0}, '{59, 0}, '{0, 59}, '{20, 20}};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Cleared store first, then saturation on hidden and output neurons, both
    // ways on the outputs, and every input pattern at least once.
    directed.push_back(make_eval(0));
    directed.push_back(make_eval(7));
    directed.push_back(make_write(0, 32767, 7));
    directed.push_back(make_write(1, 32767, 0));
    directed.push_back(make_write(2, 32767, 5));
    directed.push_back(make_write(3, -32768, 2));
    directed.push_back(make_eval(7));
    directed.push_back(make_eval(0));
    directed.push_back(make_write(20, 32767, 3));
    directed.push_back(make_write(25, -32768, 4));
    directed.push_back(make_eval(5));
    directed.push_back(make_write(26, -32768, 1));
    directed.push_back(make_write(31, 32767, 6));
    directed.push_back(make_eval(2));
    directed.push_back(make_write(4, -1, 7));
    directed.push_back(make_write(7, 256, 0));
    directed.push_back(make_eval(1));
    directed.push_back(make_eval(6));
    directed.push_back(make_write(31, 0, 7));
    directed.push_back(make_eval(3));
    directed.push_back(make_eval(4));
    foreach (directed[i]) send_word(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph][0];
      recv_stall_pct = idle_plan[ph][1];
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
      drain();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.flag_leftover();
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
